@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top RTL file of the volume block scatter addresser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VBSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VBSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vbsa_pkg.sv @@
// Package with widths, codes and types of the volume block scatter addresser.
package vbsa_pkg;

    localparam int SIZE_W   = 11;
    localparam int EDGE_W   = 9;
    localparam int BIDX_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 30;
    localparam int ORG_W    = BIDX_W + EDGE_W;
    localparam int MULA_W   = 2 * SIZE_W;
    localparam int MULB_W   = ORG_W;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_DIM_DEF        = 1024;
    localparam int MAX_BLOCK_EDGE_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 2'd2;

    localparam logic MODE_HEADER = 1'b0;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MX   = 10'b00_0000_0010,
        S_MY   = 10'b00_0000_0100,
        S_MZ   = 10'b00_0000_1000,
        S_MYX  = 10'b00_0001_0000,
        S_MXY  = 10'b00_0010_0000,
        S_MZP  = 10'b00_0100_0000,
        S_HEND = 10'b00_1000_0000,
        S_DMUL = 10'b01_0000_0000,
        S_DEND = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        state_t step;
        logic   in_ready;
    } ctrl_t;

endpackage

@@ rtl/core/volume_block_scatter_addresser.sv @@
// Header: six multiplies on the way from acceptance back to idle, where the next request is taken.
// Data byte: steps DMUL and DEND, then the result is registered; requests are taken only in idle.
// All products come from one shared registered multiplier.
// A result waiting in the output register stalls only the final data step.
// Reset (aresetn low, synchronous) clears sizes, counters, bases and closes the block.
`include "assert_macros.svh"

module volume_block_scatter_addresser #(
    parameter int MAX_DIM        = vbsa_pkg::MAX_DIM_DEF,
    parameter int MAX_BLOCK_EDGE = vbsa_pkg::MAX_BLOCK_EDGE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_edge[8:0], block_x[18:9], block_y[28:19], block_z[38:29], data_byte[46:39]
    input  logic [vbsa_pkg::S_DATA_W-1:0] s_tdata,
    // mode[0]
    input  logic                          s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // voxel_address[29:0], voxel_value[37:30]
    output logic [vbsa_pkg::M_DATA_W-1:0] m_tdata,
    // surplus[0]
    output logic                          m_tuser,
    // last_of_block
    output logic                          m_tlast,
    // Configuration channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vbsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vbsa_pkg::SIZE_W-1:0]   cfg_data
);
    import vbsa_pkg::*;

    localparam int EXT_W = $clog2(MAX_BLOCK_EDGE + 1);

    ctrl_t ctrl;
    logic  s_accept;
    logic  out_free;

    logic [SIZE_W-1:0] x_size_reg, y_size_reg, z_size_reg;
    logic [SIZE_W-1:0] xs, ys, zs;

    logic [EDGE_W-1:0] edge_in, edge_clamped, edge_reg;
    logic [BIDX_W-1:0] bx_reg, by_reg, bz_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [ORG_W-1:0]  x0_reg, y0_reg, z0_reg;
    logic [ADDR_W-1:0] yx_reg;

    logic [MULA_W-1:0] op_a;
    logic [MULB_W-1:0] op_b;
    logic [ADDR_W-1:0] prod;

    logic [EXT_W-1:0]  x_count_reg, y_count_reg, z_count_reg;
    logic [EXT_W-1:0]  x_extent_reg, y_extent_reg, z_extent_reg;
    logic [EXT_W-1:0]  x_ext_new, y_ext_new, z_ext_new;
    logic [EXT_W:0]    x_inc, y_inc, z_inc;
    logic [ADDR_W-1:0] row_base_reg, plane_base_reg;
    logic              block_done_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0]    m_addr_reg;
    logic [BYTE_W-1:0]    m_value_reg;
    logic                 m_last_reg, m_surplus_reg;

    logic                 count_ok, last_step, surplus_ok;

    // Sizes above the volume limit count as the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (32'(v) > 32'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

    // In-bounds voxel count along one axis for a block starting at lo.
    function automatic logic [EXT_W-1:0] axis_extent(input logic [ORG_W-1:0]  lo,
                                                     input logic [EDGE_W-1:0] edge_len,
                                                     input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] room;
        logic [SIZE_W-1:0] res;
        room = size - lo[SIZE_W-1:0];
        res  = 0;
        if (ORG_W'(size) > lo) begin
            res = (room < SIZE_W'(edge_len)) ? room : SIZE_W'(edge_len);
        end
        return EXT_W'(res);
    endfunction

    assign xs = clamp_size(x_size_reg);
    assign ys = clamp_size(y_size_reg);
    assign zs = clamp_size(z_size_reg);

    assign edge_in      = s_tdata[8:0];
    assign edge_clamped = (32'(edge_in) > 32'(MAX_BLOCK_EDGE)) ?
                          EDGE_W'(MAX_BLOCK_EDGE) : edge_in;

    assign s_tready  = ctrl.in_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    vbsa_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.step)
            S_MX: begin
                op_a = MULA_W'(edge_reg);
                op_b = MULB_W'(bx_reg);
            end
            S_MY: begin
                op_a = MULA_W'(edge_reg);
                op_b = MULB_W'(by_reg);
            end
            S_MZ: begin
                op_a = MULA_W'(edge_reg);
                op_b = MULB_W'(bz_reg);
            end
            S_MYX: begin
                op_a = MULA_W'(xs);
                op_b = y0_reg;
            end
            // The plane size stays in the product register while the result waits.
            S_MXY, S_DMUL, S_DEND: begin
                op_a = MULA_W'(xs);
                op_b = MULB_W'(ys);
            end
            S_MZP: begin
                // The product register holds the plane size here.
                op_a = prod[MULA_W-1:0];
                op_b = z0_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    vbsa_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_size_reg <= '0;
            y_size_reg <= '0;
            z_size_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_X_SIZE: x_size_reg <= cfg_data;
                REG_Y_SIZE: y_size_reg <= cfg_data;
                REG_Z_SIZE: z_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request payload and header products.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            edge_reg <= edge_clamped;
            bx_reg   <= s_tdata[18:9];
            by_reg   <= s_tdata[28:19];
            bz_reg   <= s_tdata[38:29];
            byte_reg <= s_tdata[46:39];
        end
        if (ctrl.step == S_MY)  x0_reg <= prod[ORG_W-1:0];
        if (ctrl.step == S_MZ)  y0_reg <= prod[ORG_W-1:0];
        if (ctrl.step == S_MYX) z0_reg <= prod[ORG_W-1:0];
        if (ctrl.step == S_MXY) yx_reg <= prod;
    end

    assign x_ext_new = axis_extent(x0_reg, edge_reg, xs);
    assign y_ext_new = axis_extent(y0_reg, edge_reg, ys);
    assign z_ext_new = axis_extent(z0_reg, edge_reg, zs);

    assign x_inc = (EXT_W + 1)'(x_count_reg) + 1'b1;
    assign y_inc = (EXT_W + 1)'(y_count_reg) + 1'b1;
    assign z_inc = (EXT_W + 1)'(z_count_reg) + 1'b1;

    // Block walk state: set up at the end of a header, advanced by each data byte of an open block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_count_reg    <= '0;
            y_count_reg    <= '0;
            z_count_reg    <= '0;
            x_extent_reg   <= '0;
            y_extent_reg   <= '0;
            z_extent_reg   <= '0;
            row_base_reg   <= '0;
            plane_base_reg <= '0;
            block_done_reg <= 1'b1;
        end else if (ctrl.step == S_HEND) begin
            x_extent_reg   <= x_ext_new;
            y_extent_reg   <= y_ext_new;
            z_extent_reg   <= z_ext_new;
            x_count_reg    <= '0;
            y_count_reg    <= '0;
            z_count_reg    <= '0;
            plane_base_reg <= ADDR_W'(x0_reg) + yx_reg + prod;
            row_base_reg   <= ADDR_W'(x0_reg) + yx_reg + prod;
            block_done_reg <= (x_ext_new == '0) || (y_ext_new == '0) || (z_ext_new == '0);
        end else if (ctrl.step == S_DEND && out_free && !block_done_reg) begin
            if (x_inc >= (EXT_W + 1)'(x_extent_reg)) begin
                x_count_reg <= '0;
                if (y_inc >= (EXT_W + 1)'(y_extent_reg)) begin
                    y_count_reg    <= '0;
                    plane_base_reg <= plane_base_reg + prod;
                    row_base_reg   <= plane_base_reg + prod;
                    if (z_inc >= (EXT_W + 1)'(z_extent_reg)) begin
                        z_count_reg    <= '0;
                        block_done_reg <= 1'b1;
                    end else begin
                        z_count_reg <= z_inc[EXT_W-1:0];
                    end
                end else begin
                    y_count_reg  <= y_inc[EXT_W-1:0];
                    row_base_reg <= row_base_reg + ADDR_W'(xs);
                end
            end else begin
                x_count_reg <= x_inc[EXT_W-1:0];
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (ctrl.step == S_DEND && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step == S_DEND && out_free) begin
            if (block_done_reg) begin
                m_addr_reg    <= '0;
                m_value_reg   <= '0;
                m_last_reg    <= 1'b0;
                m_surplus_reg <= 1'b1;
            end else begin
                m_addr_reg    <= row_base_reg + ADDR_W'(x_count_reg);
                m_value_reg   <= byte_reg;
                m_last_reg    <= (x_inc >= (EXT_W + 1)'(x_extent_reg)) &&
                                 (y_inc >= (EXT_W + 1)'(y_extent_reg)) &&
                                 (z_inc >= (EXT_W + 1)'(z_extent_reg));
                m_surplus_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - ADDR_W - BYTE_W)'(0), m_value_reg, m_addr_reg};
    assign m_tuser  = m_surplus_reg;
    assign m_tlast  = m_last_reg;

    assign count_ok   = (x_count_reg < x_extent_reg) && (y_count_reg < y_extent_reg) &&
                        (z_count_reg < z_extent_reg);
    assign last_step  = (ctrl.step == S_DEND) && out_free && !block_done_reg &&
                        (x_inc >= (EXT_W + 1)'(x_extent_reg)) &&
                        (y_inc >= (EXT_W + 1)'(y_extent_reg)) &&
                        (z_inc >= (EXT_W + 1)'(z_extent_reg));
    assign surplus_ok = !m_tlast && (m_tdata == '0);

    `VBSA_ASSERT_IMPL(a_count_in_extent, aclk, aresetn, !block_done_reg, count_ok, "walk outside extent")
    `VBSA_ASSERT_IMPL(a_surplus_not_last, aclk, aresetn, m_tvalid && m_tuser, surplus_ok, "bad surplus")
    `VBSA_ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_accept, !s_tready, "request while busy")
    `VBSA_ASSERT_NEXT(a_last_closes_block, aclk, aresetn, last_step, block_done_reg && m_tlast, "open block")

endmodule

@@ rtl/core/vbsa_mul.sv @@
// Shared multiplier with a registered product truncated to the address width.
module vbsa_mul (
    input  logic                       aclk,
    input  logic [vbsa_pkg::MULA_W-1:0] op_a,
    input  logic [vbsa_pkg::MULB_W-1:0] op_b,
    output logic [vbsa_pkg::ADDR_W-1:0] prod
);
    import vbsa_pkg::*;

    logic [MULA_W+MULB_W-1:0] full;
    logic [ADDR_W-1:0]        prod_reg;

    assign full = (MULA_W + MULB_W)'(op_a) * (MULA_W + MULB_W)'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= full[ADDR_W-1:0];
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/vbsa_seq.sv @@
// Sequencer that steps the shared multiplier through header and data work.
module vbsa_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_mode,
    input  logic            out_free,
    output vbsa_pkg::ctrl_t ctrl
);
    import vbsa_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_mode == MODE_HEADER) ? S_MX : S_DMUL;
                end
            end
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_MZ;
            S_MZ:   state_next = S_MYX;
            S_MYX:  state_next = S_MXY;
            S_MXY:  state_next = S_MZP;
            S_MZP:  state_next = S_HEND;
            S_HEND: state_next = S_IDLE;
            S_DMUL: state_next = S_DEND;
            S_DEND: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign ctrl.step     = state_reg;
    assign ctrl.in_ready = (state_reg == S_IDLE);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the volume block scatter addresser with its own address predictor.
`timescale 1ns / 100ps

module tb_top;
    import vbsa_pkg::*;

    localparam logic MODE_DATA = 1'b1;
    localparam longint unsigned ADDR_MASK = (64'd1 << ADDR_W) - 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] value;
        logic              last_mark;
        logic              surplus;
    } voxel_write_t;

    class scatter_scoreboard;
        logic [SIZE_W-1:0] size_reg[3];
        longint unsigned x_pos, y_pos, z_pos;
        longint unsigned x_span, y_span, z_span;
        longint unsigned row_addr, plane_addr;
        bit block_closed;
        voxel_write_t expected_writes[$];
        int errors;

        function new();
            size_reg = '{default: '0};
            x_pos = 0; y_pos = 0; z_pos = 0;
            x_span = 0; y_span = 0; z_span = 0;
            row_addr = 0; plane_addr = 0;
            block_closed = 1'b1;
            errors = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
            case (index)
                REG_X_SIZE: size_reg[0] = value;
                REG_Y_SIZE: size_reg[1] = value;
                REG_Z_SIZE: size_reg[2] = value;
                default: ;
            endcase
        endfunction

        // Sizes beyond the largest supported volume act as the largest one.
        function longint unsigned axis_size(int axis);
            longint unsigned s;
            s = size_reg[axis];
            return (s > MAX_DIM_DEF) ? MAX_DIM_DEF : s;
        endfunction

        function longint unsigned span_of(longint unsigned lo, longint unsigned edge_len,
                                          longint unsigned size_n);
            if (lo >= size_n) return 0;
            return (size_n - lo < edge_len) ? size_n - lo : edge_len;
        endfunction

        function longint unsigned voxels_left();
            if (block_closed) return 0;
            return x_span * y_span * z_span - ((z_pos * y_span + y_pos) * x_span + x_pos);
        endfunction

        function void note_request(logic mode, logic [S_DATA_W-1:0] data);
            longint unsigned edge_len, xs, ys, zs, x0, y0, z0;
            voxel_write_t w;
            xs = axis_size(0);
            ys = axis_size(1);
            zs = axis_size(2);
            if (mode == MODE_HEADER) begin
                edge_len = data[8:0];
                if (edge_len > MAX_BLOCK_EDGE_DEF) edge_len = MAX_BLOCK_EDGE_DEF;
                x0 = longint'(data[18:9]) * edge_len;
                y0 = longint'(data[28:19]) * edge_len;
                z0 = longint'(data[38:29]) * edge_len;
                x_span = span_of(x0, edge_len, xs);
                y_span = span_of(y0, edge_len, ys);
                z_span = span_of(z0, edge_len, zs);
                x_pos = 0; y_pos = 0; z_pos = 0;
                plane_addr = (x0 + y0 * xs + z0 * xs * ys) & ADDR_MASK;
                row_addr = plane_addr;
                block_closed = (x_span == 0 || y_span == 0 || z_span == 0);
                return;
            end
            if (block_closed) begin
                w = '{address: '0, value: '0, last_mark: 1'b0, surplus: 1'b1};
                expected_writes.push_back(w);
                return;
            end
            w.address = ADDR_W'((row_addr + x_pos) & ADDR_MASK);
            w.value = data[46:39];
            w.last_mark = 1'b0;
            w.surplus = 1'b0;
            // Advance x first, then wrap into the next row and the next plane.
            x_pos++;
            if (x_pos >= x_span) begin
                x_pos = 0;
                y_pos++;
                row_addr = (row_addr + xs) & ADDR_MASK;
                if (y_pos >= y_span) begin
                    y_pos = 0;
                    z_pos++;
                    plane_addr = (plane_addr + xs * ys) & ADDR_MASK;
                    row_addr = plane_addr;
                    if (z_pos >= z_span) begin
                        z_pos = 0;
                        block_closed = 1'b1;
                        w.last_mark = 1'b1;
                    end
                end
            end
            expected_writes.push_back(w);
        endfunction

        function void check_write(logic [M_DATA_W-1:0] tdata, logic surplus, logic last_mark);
            voxel_write_t w;
            if (expected_writes.size() == 0) begin
                $error("unexpected write: voxel_address %0h, voxel_value %0h",
                       tdata[29:0], tdata[37:30]);
                errors++;
                return;
            end
            w = expected_writes.pop_front();
            if (tdata[29:0] !== w.address) begin
                $error("voxel_address mismatch: expected %0h, actual %0h",
                       w.address, tdata[29:0]);
                errors++;
            end
            if (tdata[37:30] !== w.value) begin
                $error("voxel_value mismatch: expected %0h, actual %0h",
                       w.value, tdata[37:30]);
                errors++;
            end
            if (last_mark !== w.last_mark) begin
                $error("last_of_block mismatch: expected %0b, actual %0b",
                       w.last_mark, last_mark);
                errors++;
            end
            if (surplus !== w.surplus) begin
                $error("surplus mismatch: expected %0b, actual %0b", w.surplus, surplus);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    scatter_scoreboard sb = new();
    bit quiet_tail = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int cycles_elapsed;

    volume_block_scatter_addresser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles_elapsed = 0;
        while (cycles_elapsed < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_elapsed++;
        end
        $display("volume_block_scatter_addresser test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_write(m_tdata, m_tuser, m_tlast);
    end

    // Result side: random stall bursts, one long hold-off on request, none at the tail.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_request(logic [8:0] edge_len, logic [9:0] bx,
                                                         logic [9:0] by, logic [9:0] bz,
                                                         logic [7:0] voxel);
        return {1'b0, voxel, bz, by, bx, edge_len};
    endfunction

    task automatic send_request(input logic mode, input logic [S_DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(mode, data);
        items_sent++;
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Fields that a mode does not use carry random bits so that those bits toggle.
    task automatic send_header(input int unsigned edge_len, input int unsigned bx,
                               input int unsigned by, input int unsigned bz);
        send_request(MODE_HEADER, pack_request(9'(edge_len), 10'(bx), 10'(by), 10'(bz),
                                               8'($urandom_range(0, 255))));
    endtask

    task automatic send_voxel(input int unsigned voxel);
        send_request(MODE_DATA, pack_request(9'($urandom_range(0, 511)),
                                             10'($urandom_range(0, 1023)),
                                             10'($urandom_range(0, 1023)),
                                             10'($urandom_range(0, 1023)), 8'(voxel)));
    endtask

    task automatic configure(input int unsigned xs, input int unsigned ys, input int unsigned zs);
        logic [SIZE_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0] regs[3];
        vals = '{SIZE_W'(xs), SIZE_W'(ys), SIZE_W'(zs)};
        regs = '{REG_X_SIZE, REG_Y_SIZE, REG_Z_SIZE};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_size(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every expected write, then give a header time to finish.
    task automatic settle();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (sb.expected_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One header placed inside the volume followed by its bytes; sometimes cut short or overrun.
    task automatic run_block();
        int unsigned edge_len, eff, pick;
        int unsigned idx[3];
        longint unsigned s, n;
        pick = $urandom_range(0, 9);
        if (pick < 7) edge_len = $urandom_range(1, 6);
        else if (pick < 9) edge_len = $urandom_range(7, 40);
        else edge_len = $urandom_range(41, 511);
        eff = (edge_len > MAX_BLOCK_EDGE_DEF) ? MAX_BLOCK_EDGE_DEF : edge_len;
        for (int a = 0; a < 3; a++) begin
            s = sb.axis_size(a);
            idx[a] = (s == 0) ? $urandom_range(0, 1023) : $urandom_range(0, (s - 1) / eff);
        end
        send_header(edge_len, idx[0], idx[1], idx[2]);
        n = sb.voxels_left();
        if (n > 200) n = $urandom_range(1, 200);
        else if (n > 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
        repeat (n) send_voxel($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_voxel($urandom_range(0, 255));
    endtask

    initial begin
        int random_start;
        bit held;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_HEADER;
        cfg_valid <= 1'b0;
        cfg_index <= REG_X_SIZE;
        cfg_data <= '0;
        held = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        configure(7, 5, 3);
        // A byte with no block open is surplus.
        send_voxel(8'h00);
        // Block clipped along all three axes: 3 x 1 x 3 voxels, then one byte too many.
        send_header(4, 1, 1, 0);
        send_voxel(8'hFF);
        repeat (8) send_voxel($urandom_range(0, 255));
        send_voxel(8'hA5);
        // Zero edge opens an empty block.
        send_header(0, 0, 0, 0);
        send_voxel(8'h5A);
        // Oversized edge, abandoned by a header lying wholly outside the volume.
        send_header(511, 0, 0, 0);
        send_voxel(8'h01);
        send_voxel(8'h80);
        send_header(2, 1023, 1023, 1023);
        send_voxel(8'h7F);
        // Sizes change while a block is open; the rest of the block uses the new row pitch.
        send_header(3, 2, 1, 0);
        repeat (3) send_voxel($urandom_range(0, 255));
        settle();
        configure(2047, 5, 3);
        repeat (3) send_voxel($urandom_range(0, 255));
        send_voxel(8'hC3);
        settle();

        random_start = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                2: configure(0, $urandom_range(1, 12), $urandom_range(1, 12));
                3: configure(1024, 1024, 1024);
                4: configure(2047, 3, 2047);
                5: configure(1, 1, 1);
                6: configure($urandom_range(1, 40), $urandom_range(1, 6), $urandom_range(1, 6));
                default: configure($urandom_range(1, 12), $urandom_range(1, 12),
                                   $urandom_range(1, 12));
            endcase
            while (items_sent - random_start < (p + 1) * RANDOM_ITEMS / PHASES) begin
                quiet_tail = (items_sent - random_start >= RANDOM_ITEMS - 80);
                if (!held && items_sent - random_start >= 150) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if ($urandom_range(0, 4) != 0) begin
                    run_block();
                end else if ($urandom_range(0, 1) == 0) begin
                    send_header($urandom_range(0, 511), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023));
                end else begin
                    send_voxel($urandom_range(0, 255));
                end
            end
            settle();
        end

        if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
            $display("volume_block_scatter_addresser test passed");
        end else begin
            $display("volume_block_scatter_addresser test failed");
        end
        $finish;
    end

endmodule
